// ===== rtl/ftsd_pkg.sv =====
// Shared types, constants and power tables for the float to scaled decimal converter
`default_nettype none

package ftsd_pkg;

    // widths of the shared datapath
    localparam int W_WIDE = 128;
    localparam int W_Q    = 26;
    localparam int W_QUO  = 27;
    localparam int W_PROD = 58;

    typedef logic [W_WIDE-1:0] t_wide;
    typedef t_wide t_tab [0:63];

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic       clr;
        logic       en;
        logic [1:0] chunk;
    } t_mac_ctl;

    // status of the shift-subtract divider
    typedef struct packed {
        logic busy;
        logic sticky;
    } t_div_sts;

    // float decoding limits
    localparam logic [7:0]  EXP_SPECIAL = 8'd255;
    localparam logic [7:0]  EXP_BIG     = 8'd223;
    localparam logic [30:0] SMALL_LIMIT = 31'((33 << 23) | 8226742);

    // seven digit window and the other fixed numbers
    localparam logic [24:0] DIGITS_LO  = 25'd1000000;
    localparam logic [24:0] DIGITS_HI  = 25'd10000000;
    localparam logic [31:0] RECIP10    = 32'hCCCCCCCD;
    localparam logic [5:0]  SCALE_MAX  = 6'd28;
    localparam logic [5:0]  DROP_MAX   = 6'd8;
    localparam logic [3:0]  MAX_ITER   = 4'd8;
    localparam logic [4:0]  DIV_STEPS  = 5'd27;

    // powers of a base, worked out at elaboration
    function automatic t_tab f_pow_tab(input int base);
        t_tab tab;
        tab[0] = 128'd1;
        for (int i = 1; i < 64; i++) begin
            tab[i] = tab[i-1] * 128'(base);
        end
        return tab;
    endfunction

    localparam t_tab POW10 = f_pow_tab(10);
    localparam t_tab POW5  = f_pow_tab(5);

endpackage

`default_nettype wire

// ===== rtl/float_to_scaled_decimal.sv =====
// Top level: sequencer around the shared multiplier and divider
//
// Converts one single-precision word into a 96-bit coefficient, a decimal scale of
// 0 to 28 and a sign, rounding the exact value to 7 significant digits half-even.
// Infinity, NaN, magnitudes of 2^96 and above, and nonzero magnitudes below 1e-28
// give conv_error with a zero result. These and zeros go straight to the result.
// Other values run the digit-window search (at most 8 passes), each pass forming
// a 7-digit quotient on the 27-step shift-subtract divider, then round, strip
// trailing zeros and either scale up by a power of ten for an integer result or,
// when the scale would pass 28, divide with half-up rounding down to scale 28.
// One request is in flight at a time; o_stall stays high from acceptance until the
// result is taken.
`default_nettype none

module float_to_scaled_decimal #(
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [31:0]  i_float_bits,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [63:0]       o_coef_low,
    output logic [31:0]       o_coef_high,
    output logic [4:0]        o_dec_scale,
    output logic              o_negative,
    output logic              o_conv_error
);
    import ftsd_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EST    = 4'd1;
    localparam logic [3:0] S_PREP   = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_SHIFT  = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_CHK    = 4'd6;
    localparam logic [3:0] S_ROUND  = 4'd7;
    localparam logic [3:0] S_STRIP  = 4'd8;
    localparam logic [3:0] S_POW    = 4'd9;
    localparam logic [3:0] S_POWD   = 4'd10;
    localparam logic [3:0] S_DROP   = 4'd11;
    localparam logic [3:0] S_RDIV   = 4'd12;
    localparam logic [3:0] S_RSTRIP = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    logic [3:0]         r_state, n_state;
    logic [3:0]         r_iter, n_iter;
    logic [1:0]         r_cnt, n_cnt;
    logic               r_neg, n_neg;
    logic               r_err, n_err;
    logic [23:0]        r_m2, n_m2;
    logic signed [8:0]  r_e2, n_e2;
    logic signed [7:0]  r_d, n_d;
    logic signed [7:0]  r_k, n_k;
    logic signed [9:0]  r_b, n_b;
    logic [5:0]         r_j, n_j;
    logic [W_Q-1:0]     r_q2, n_q2;
    logic               r_sticky, n_sticky;
    logic [W_Q-1:0]     r_q, n_q;
    logic signed [7:0]  r_x, n_x;
    logic [5:0]         r_sc, n_sc;
    logic [95:0]        r_coef, n_coef;
    logic [4:0]         r_scale, n_scale;

    // shared unit connections
    t_mac_ctl           mac_ctl;
    logic [25:0]        mac_a;
    logic [31:0]        mac_b;
    logic [57:0]        mac_prod;
    logic [W_WIDE-1:0]  mac_acc;
    logic               div_load;
    logic [W_WIDE-1:0]  div_num;
    logic [W_WIDE-1:0]  div_den;
    t_div_sts           div_sts;
    logic [W_QUO-1:0]   div_quo;

    // helper signals
    logic               in_acc;
    logic [7:0]         f_ex;
    logic [30:0]        f_mag;
    logic               f_err;
    logic [4:0]         len;
    logic signed [9:0]  est_t;
    logic signed [21:0] est_prod;
    logic [22:0]        quo10;
    logic [W_Q-1:0]     rem10;
    logic               strip_ok;
    logic [5:0]         drop;
    t_wide              pw_sel;
    logic [9:0]         bmag;
    t_wide              base;
    t_wide              den0;
    logic signed [7:0]  k_new;
    logic signed [9:0]  p_new;
    logic [24:0]        qf;
    logic [W_Q-1:0]     q_rnd;
    logic signed [7:0]  d_rnd;
    logic [7:0]         neg_x;

    ftsd_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_a    (mac_a),
        .i_b    (mac_b),
        .o_prod (mac_prod),
        .o_acc  (mac_acc)
    );

    ftsd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (div_load),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_sts   (div_sts),
        .o_quo   (div_quo)
    );

    // request decode
    assign in_acc = i_valid && !o_stall;
    assign f_ex   = i_float_bits[30:23];
    assign f_mag  = i_float_bits[30:0];
    assign f_err  = (f_ex == EXP_SPECIAL) || (f_ex >= EXP_BIG) ||
                    ((f_mag != 31'd0) && (f_mag < SMALL_LIMIT));

    // bit length of the significand
    always_comb begin
        len = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (r_m2[i]) begin
                len = 5'(i + 1);
            end
        end
    end

    // decimal exponent estimate, floor(t * log10 2)
    assign est_t    = 10'(r_e2) + 10'(len) - 10'sd1;
    assign est_prod = 22'(est_t) * 22'sd1233;

    // divide by ten through the reciprocal
    assign quo10    = mac_prod[57:35];
    assign rem10    = r_q - ({quo10, 3'b000} + 26'({quo10, 1'b0}));
    assign strip_ok = (r_q != '0) && (rem10 == '0);
    assign drop     = r_sc - SCALE_MAX;

    // window operands
    assign k_new = r_d - 8'sd6;
    assign p_new = 10'(r_e2) + 10'sd1;
    assign bmag  = r_b[9] ? 10'(-r_b) : 10'(r_b);
    assign base  = (!r_k[7] && (r_k != 8'sd0)) ? POW5[r_k[5:0]] : 128'd1;
    assign den0  = r_b[9] ? (base << bmag) : base;
    assign qf    = div_quo[25:1];
    assign neg_x = 8'(-r_x);

    // half-even rounding of the doubled quotient
    always_comb begin
        q_rnd = {1'b0, r_q2[W_Q-1:1]} + W_Q'(r_q2[0] & (r_sticky | r_q2[1]));
        d_rnd = r_d;
        if (q_rnd >= W_Q'(DIGITS_HI)) begin
            q_rnd = W_Q'(DIGITS_LO);
            d_rnd = r_d + 8'sd1;
        end
    end

    // multiplier operand selection
    always_comb begin
        pw_sel = (r_state == S_POW) ? POW10[r_x[5:0]] : POW5[r_j];
        mac_a  = r_q;
        mac_b  = pw_sel[{r_cnt, 5'd0} +: 32];
        if (r_state == S_MUL) begin
            mac_a = W_Q'(r_m2);
        end else if (r_state == S_STRIP || r_state == S_RSTRIP) begin
            mac_b = RECIP10;
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_iter   = r_iter;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        n_err    = r_err;
        n_m2     = r_m2;
        n_e2     = r_e2;
        n_d      = r_d;
        n_k      = r_k;
        n_b      = r_b;
        n_j      = r_j;
        n_q2     = r_q2;
        n_sticky = r_sticky;
        n_q      = r_q;
        n_x      = r_x;
        n_sc     = r_sc;
        n_coef   = r_coef;
        n_scale  = r_scale;
        mac_ctl  = '0;
        div_load = 1'b0;
        div_num  = '0;
        div_den  = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_err   = f_err;
                    n_neg   = f_err ? 1'b0 : i_float_bits[31];
                    n_coef  = '0;
                    n_scale = '0;
                    n_iter  = '0;
                    if (f_ex == 8'd0) begin
                        n_m2 = {1'b0, i_float_bits[22:0]};
                        n_e2 = -9'sd149;
                    end else begin
                        n_m2 = {1'b1, i_float_bits[22:0]};
                        n_e2 = $signed({1'b0, f_ex}) - 9'sd150;
                    end
                    if (f_err || f_mag == 31'd0) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_EST;
                    end
                end
            end
            S_EST: begin
                n_d     = 8'(est_prod >>> 12);
                n_state = S_PREP;
            end
            S_PREP: begin
                n_k         = k_new;
                n_b         = p_new - 10'(k_new);
                n_j         = k_new[7] ? 6'(-k_new) : 6'd0;
                n_cnt       = 2'd0;
                mac_ctl.clr = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                mac_ctl.en    = 1'b1;
                mac_ctl.chunk = r_cnt;
                n_cnt         = r_cnt + 2'd1;
                if (r_cnt == 2'd2) begin
                    n_cnt   = 2'd0;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                div_load = 1'b1;
                div_num  = r_b[9] ? mac_acc : (mac_acc << bmag);
                div_den  = den0 << 26;
                n_state  = S_DIV;
            end
            S_DIV: begin
                if (!div_sts.busy) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_q2     = div_quo[W_QUO-1] ? '1 : div_quo[W_Q-1:0];
                n_sticky = div_sts.sticky;
                n_iter   = r_iter + 4'd1;
                if (div_quo[W_QUO-1] || qf >= DIGITS_HI) begin
                    n_d     = r_d + 8'sd1;
                    n_state = (r_iter + 4'd1 == MAX_ITER) ? S_ROUND : S_PREP;
                end else if (qf < DIGITS_LO) begin
                    n_d     = r_d - 8'sd1;
                    n_state = (r_iter + 4'd1 == MAX_ITER) ? S_ROUND : S_PREP;
                end else begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                n_q     = q_rnd;
                n_d     = d_rnd;
                n_x     = d_rnd - 8'sd6;
                n_state = S_STRIP;
            end
            S_STRIP: begin
                mac_ctl.clr = 1'b1;
                if (strip_ok) begin
                    n_q = W_Q'(quo10);
                    n_x = r_x + 8'sd1;
                end else if (!r_x[7]) begin
                    n_cnt   = 2'd0;
                    n_state = S_POW;
                end else begin
                    n_sc = neg_x[5:0];
                    if (neg_x[5:0] > SCALE_MAX) begin
                        n_state = S_DROP;
                    end else begin
                        n_coef  = 96'(r_q);
                        n_scale = neg_x[4:0];
                        n_state = S_OUT;
                    end
                end
            end
            S_POW: begin
                mac_ctl.en    = 1'b1;
                mac_ctl.chunk = r_cnt;
                n_cnt         = r_cnt + 2'd1;
                if (r_cnt == 2'd2) begin
                    n_cnt   = 2'd0;
                    n_state = S_POWD;
                end
            end
            S_POWD: begin
                n_coef  = mac_acc[95:0];
                n_scale = '0;
                n_state = S_OUT;
            end
            S_DROP: begin
                if (drop > DROP_MAX) begin
                    n_q     = '0;
                    n_coef  = '0;
                    n_scale = '0;
                    n_state = S_OUT;
                end else begin
                    div_load = 1'b1;
                    div_num  = W_WIDE'(r_q) + (POW10[drop] >> 1);
                    div_den  = POW10[drop] << 26;
                    n_sc     = SCALE_MAX;
                    n_state  = S_RDIV;
                end
            end
            S_RDIV: begin
                if (!div_sts.busy) begin
                    n_q     = div_quo[W_Q-1:0];
                    n_state = S_RSTRIP;
                end
            end
            S_RSTRIP: begin
                if (r_sc != 6'd0 && strip_ok) begin
                    n_q  = W_Q'(quo10);
                    n_sc = r_sc - 6'd1;
                end else begin
                    n_coef  = 96'(r_q);
                    n_scale = (r_q == '0) ? 5'd0 : r_sc[4:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
            r_cnt   <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_neg    <= n_neg;
        r_err    <= n_err;
        r_m2     <= n_m2;
        r_e2     <= n_e2;
        r_d      <= n_d;
        r_k      <= n_k;
        r_b      <= n_b;
        r_j      <= n_j;
        r_q2     <= n_q2;
        r_sticky <= n_sticky;
        r_q      <= n_q;
        r_x      <= n_x;
        r_sc     <= n_sc;
        r_coef   <= n_coef;
        r_scale  <= n_scale;
    end

    // ports
    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = (r_state == S_OUT);
    assign o_coef_low   = r_coef[63:0];
    assign o_coef_high  = r_coef[95:64];
    assign o_dec_scale  = r_scale;
    assign o_negative   = r_neg;
    assign o_conv_error = r_err;

    // an error result carries nothing else
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_conv_error) |-> (o_coef_low == 64'd0 && o_coef_high == 32'd0 &&
                                       o_dec_scale == 5'd0 && !o_negative))
        else $error("error result not cleared");

    // scale stays within the decimal range
    a_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_dec_scale <= 5'd28))
        else $error("scale above 28");

    // a fractional result never has a zero coefficient
    a_frac_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dec_scale != 5'd0) |-> (o_coef_low != 64'd0))
        else $error("zero coefficient with nonzero scale");

    // no new request while a result is pending
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("request taken with result pending");

endmodule

`default_nettype wire

// ===== rtl/ftsd_mac.sv =====
// Shared 26x32 multiplier with a chunk-shifted 128-bit accumulator
`default_nettype none

module ftsd_mac (
    input  wire logic                i_clk,
    input  wire ftsd_pkg::t_mac_ctl  i_ctl,
    input  wire logic [25:0]         i_a,
    input  wire logic [31:0]         i_b,
    output logic [57:0]              o_prod,
    output logic [127:0]             o_acc
);
    import ftsd_pkg::*;

    logic [W_WIDE-1:0] r_acc;
    logic [W_WIDE-1:0] n_acc;
    logic [W_WIDE-1:0] prod_sh;

    // one partial product per cycle
    assign o_prod  = W_PROD'(i_a) * W_PROD'(i_b);
    assign prod_sh = W_WIDE'(o_prod) << {i_ctl.chunk, 5'd0};

    // accumulate at the selected 32-bit chunk
    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clr) begin
            n_acc = '0;
        end else if (i_ctl.en) begin
            n_acc = r_acc + prod_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

// ===== rtl/ftsd_div.sv =====
// Restoring shift-subtract divider, one quotient bit per cycle
`default_nettype none

module ftsd_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire logic [127:0]        i_num,
    input  wire logic [127:0]        i_den,
    output ftsd_pkg::t_div_sts       o_sts,
    output logic [26:0]              o_quo
);
    import ftsd_pkg::*;

    logic [W_WIDE-1:0] r_rem, n_rem;
    logic [W_WIDE-1:0] r_den, n_den;
    logic [W_QUO-1:0]  r_quo, n_quo;
    logic [4:0]        r_cnt, n_cnt;
    logic              ge;

    assign ge = (r_rem >= r_den);

    // one compare and subtract a step, divisor walks right
    always_comb begin
        n_rem = r_rem;
        n_den = r_den;
        n_quo = r_quo;
        n_cnt = r_cnt;
        if (i_load) begin
            n_rem = i_num;
            n_den = i_den;
            n_quo = '0;
            n_cnt = DIV_STEPS;
        end else if (r_cnt != 5'd0) begin
            if (ge) begin
                n_rem = r_rem - r_den;
            end
            n_quo = {r_quo[W_QUO-2:0], ge};
            n_den = r_den >> 1;
            n_cnt = r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 5'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_sts.busy   = (r_cnt != 5'd0);
    assign o_sts.sticky = (r_rem != '0);
    assign o_quo        = r_quo;

    // step counter never passes its load value
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DIV_STEPS)
        else $error("divider step count out of range");

    // a load always starts a full run
    a_load_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_cnt == DIV_STEPS))
        else $error("divider load did not start a run");

    // a running step consumes exactly one count
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_load && r_cnt != 5'd0) |=> (r_cnt == $past(r_cnt) - 5'd1))
        else $error("divider step count skipped");

endmodule

`default_nettype wire
